/* rtl/mpsm_pkg.sv */
// Package for the multi-pattern string matcher.
// Field widths, store sizes and the payload and control structs; no dependencies.
`timescale 1ns / 1ps
package mpsm_pkg;
  localparam int NodeCount = 1024;
  localparam int EdgeCount = 4096;
  localparam int MaxKeywordLen = 32;
  localparam int MaxResults = 32;
  localparam int NodeW = $clog2(NodeCount);
  localparam int EdgeW = $clog2(EdgeCount);
  localparam int SymW = 21;
  localparam int IdW = 24;
  localparam int TotW = 13;
  localparam int WalkW = $clog2(MaxKeywordLen + 2);

  localparam logic [1:0] ModeNode = 2'd0;
  localparam logic [1:0] ModeEdge = 2'd1;
  localparam logic [1:0] ModeText = 2'd2;

  typedef struct packed {
    logic [1:0]      mode;
    logic [11:0]     addr;
    logic [11:0]     edge_base;
    logic [12:0]     edge_total;
    logic [9:0]      fail_node;
    logic [9:0]      dict_node;
    logic            final_flag;
    logic [23:0]     keyword_id;
    logic [20:0]     symbol;
    logic [9:0]      child_node;
    logic            restart;
  } in_beat_t;

  typedef struct packed {
    logic [23:0] match_id;
    logic        last_match;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;     // latch input beat, apply restart
    logic rd_node;     // read node stores at node_q
    logic range_init;  // set lo/hi from node read
    logic rd_edge;     // read edge at mid
    logic step_search; // update lo/hi from edge compare
    logic go_fail;     // node_q <= fail link
    logic commit;      // cur, node_q <= child of the hit edge
    logic go_root;     // cur, node_q <= root
    logic go_dict;     // node_q <= dict link
    logic hold;        // keep id of the current final node
    logic emit;        // load output register from the held id
    logic set_last;    // emitted beat is last
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic range_empty; // lo > hi
    logic hit;         // edge symbol equals text symbol
    logic node_root;
    logic node_final;
    logic dict_zero;
  } stat_t;
endpackage

/* rtl/mpsm_datapath.sv */
// Datapath: automaton stores, binary search registers, walk registers.
// Depends on mpsm_pkg.
`timescale 1ns / 1ps
module mpsm_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mpsm_pkg::in_beat_t in_i,
  input  logic               in_take_i,
  input  mpsm_pkg::cmd_t     cmd_i,
  output mpsm_pkg::stat_t    stat_o,
  output mpsm_pkg::out_beat_t res_o
);
  import mpsm_pkg::*;

  logic [44:0] links_mem [NodeCount];
  logic [24:0] edges_mem [NodeCount];
  logic [30:0] edge_mem  [EdgeCount];

  logic [NodeW-1:0] cur_q, node_q;
  logic [SymW-1:0]  sym_q;
  logic [44:0]      links_q;
  logic [24:0]      nedg_q;
  logic             node_ok_q;
  logic [30:0]      edge_q;
  logic [TotW:0]    lo_q, hi_q;   // signed-free: hi stored +1 offset
  logic [EdgeW-1:0] base_q;
  logic [IdW-1:0]   pend_q;
  out_beat_t        res_q;

  // hi_q holds hi+1 so it never goes negative
  logic [TotW:0] mid;
  assign mid = (lo_q + hi_q - 1'b1) >> 1;

  always_ff @(posedge clk_i) begin
    if (in_take_i && in_i.mode == ModeNode && in_i.addr < 12'(NodeCount)) begin
      links_mem[in_i.addr[NodeW-1:0]] <= {in_i.fail_node, in_i.dict_node,
                                          in_i.final_flag, in_i.keyword_id};
      edges_mem[in_i.addr[NodeW-1:0]] <= {in_i.edge_total, in_i.edge_base};
    end
    // every 12-bit slot address exists in the edge store
    if (in_take_i && in_i.mode == ModeEdge) begin
      edge_mem[in_i.addr[EdgeW-1:0]] <= {in_i.child_node, in_i.symbol};
    end
    if (cmd_i.rd_node) begin
      links_q <= links_mem[node_q];
      nedg_q  <= edges_mem[node_q];
    end
    if (cmd_i.rd_edge) edge_q <= edge_mem[base_q + mid[EdgeW-1:0]];
  end

  logic [12:0] tot_raw, avail, tot_clip;
  logic [11:0] base_raw;
  assign base_raw = nedg_q[11:0];
  assign tot_raw  = nedg_q[24:12];
  assign avail    = 13'(EdgeCount) - 13'(base_raw);
  assign tot_clip = (tot_raw > avail) ? avail : tot_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      node_q <= '0;
    end else begin
      if (cmd_i.load_in) begin
        if (in_i.restart) begin
          cur_q  <= '0;
          node_q <= '0;
        end else begin
          node_q <= cur_q;
        end
      end
      if (cmd_i.go_fail) node_q <= node_ok_q ? links_q[44:35] : '0;
      if (cmd_i.commit) begin
        cur_q  <= edge_q[30:21];
        node_q <= edge_q[30:21];
      end
      if (cmd_i.go_root) begin
        cur_q  <= '0;
        node_q <= '0;
      end
      if (cmd_i.go_dict) node_q <= node_ok_q ? links_q[34:25] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) sym_q <= in_i.symbol;
    if (cmd_i.rd_node) node_ok_q <= 1'b1;
    if (cmd_i.range_init) begin
      lo_q   <= '0;
      hi_q   <= {1'b0, tot_clip};
      base_q <= base_raw[EdgeW-1:0];
    end
    if (cmd_i.step_search) begin
      if (edge_q[20:0] < sym_q) lo_q <= mid + 1'b1;
      else hi_q <= mid;
    end
    if (cmd_i.hold) pend_q <= links_q[23:0];
    if (cmd_i.emit) begin
      res_q.match_id   <= pend_q;
      res_q.last_match <= cmd_i.set_last;
    end
  end

  assign stat_o.range_empty = (lo_q >= hi_q);
  assign stat_o.hit         = (edge_q[20:0] == sym_q);
  assign stat_o.node_root   = (node_q == '0);
  assign stat_o.node_final  = links_q[24];
  assign stat_o.dict_zero   = (links_q[34:25] == '0);
  assign res_o = res_q;
endmodule

/* rtl/mpsm_ctrl.sv */
// Controller: sequences failure walk, binary search and dictionary walk.
// Depends on mpsm_pkg.
`timescale 1ns / 1ps
module mpsm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  mpsm_pkg::in_beat_t in_i,
  output logic               in_stall_o,
  output logic               in_take_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  mpsm_pkg::stat_t    stat_i,
  output mpsm_pkg::cmd_t     cmd_o
);
  import mpsm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RDN, S_INIT, S_CHK, S_RDE, S_CMP, S_DRD, S_DCHK, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic [WalkW-1:0] walk_q, walk_d;     // fail steps / dict visits
  logic [5:0]       cnt_q, cnt_d;       // ids found so far
  logic             ovalid_q, ovalid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_take_o   = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;

  logic out_free;
  assign out_free = !ovalid_q || !out_stall_i;

  logic [5:0] hits;
  logic       walk_end;
  assign hits     = cnt_q + 6'(stat_i.node_final);
  assign walk_end = stat_i.dict_zero || walk_q == WalkW'(MaxKeywordLen - 1) ||
                    hits == 6'(MaxResults);

  always_comb begin
    state_d  = state_q;
    walk_d   = walk_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && out_stall_i;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: if (in_take_o && in_i.mode == ModeText) begin
        cmd_o.load_in = 1'b1;
        walk_d = '0;
        state_d = S_RDN;
      end
      S_RDN: begin
        cmd_o.rd_node = 1'b1;
        state_d = S_INIT;
      end
      S_INIT: begin
        cmd_o.range_init = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (!stat_i.range_empty) begin
          state_d = S_RDE;
        end else if (stat_i.node_root || walk_q == WalkW'(MaxKeywordLen)) begin
          // no edge found: continue from the root
          cmd_o.go_root = 1'b1;
          walk_d = '0;
          cnt_d = '0;
          state_d = S_DRD;
        end else begin
          cmd_o.go_fail = 1'b1;
          walk_d = walk_q + 1'b1;
          state_d = S_RDN;
        end
      end
      S_RDE: begin
        cmd_o.rd_edge = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (stat_i.hit) begin
          cmd_o.commit = 1'b1;
          walk_d = '0;
          cnt_d = '0;
          state_d = S_DRD;
        end else begin
          cmd_o.step_search = 1'b1;
          state_d = S_CHK;
        end
      end
      S_DRD: begin
        cmd_o.rd_node = 1'b1;
        state_d = S_DCHK;
      end
      S_DCHK: begin
        // each id is held one step, so the last flag is known when it leaves
        if (!(stat_i.node_final && cnt_q != '0 && !out_free)) begin
          if (stat_i.node_final) begin
            cmd_o.hold = 1'b1;
            if (cnt_q != '0) begin
              cmd_o.emit = 1'b1;
              ovalid_d = 1'b1;
            end
          end
          cnt_d = hits;
          walk_d = walk_q + 1'b1;
          if (walk_end) begin
            state_d = (hits == '0) ? S_IDLE : S_OUT;
          end else begin
            cmd_o.go_dict = 1'b1;
            state_d = S_DRD;
          end
        end
      end
      S_OUT: if (out_free) begin
        cmd_o.emit = 1'b1;
        cmd_o.set_last = 1'b1;
        ovalid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      walk_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      walk_q   <= walk_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_take_o) else $error("take while busy");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> out_free) else $error("emit over pending beat");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 6'(MaxResults)) else $error("result count overflow");
  a_last_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.set_last |-> (state_q == S_OUT)) else $error("last flag outside flush");
endmodule

/* rtl/multi_pattern_string_matcher.sv */
// Aho-Corasick matcher: a load beat is written to the stores when taken. A text
// beat is accepted, walks failure links binary-searching each node's edges, walks
// dictionary links sending match ids, then sends the last match if any; output
// stall can hold it. One beat in flight; the next is taken in idle.
// Reset (async, low) clears the current node to root and the controller;
// the automaton stores are not cleared and must be loaded before use.
`timescale 1ns / 1ps
module multi_pattern_string_matcher (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mpsm_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mpsm_pkg::out_beat_t out_data_o
);
  import mpsm_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  take;

  mpsm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_i(in_data_i), .in_stall_o,
    .in_take_o(take), .out_valid_o, .out_stall_i, .stat_i(stat), .cmd_o(cmd)
  );

  mpsm_datapath u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .in_take_i(take),
    .cmd_i(cmd), .stat_o(stat), .res_o(out_data_o)
  );
endmodule
